@@ design/levitation_cascade_pid_controller_assert.svh @@
// Assertion helpers for the levitation controller.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LEVITATION_CASCADE_PID_CONTROLLER_ASSERT_SVH
`define LEVITATION_CASCADE_PID_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define LCPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LCPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcpc_pkg
// Types, constants and arithmetic helpers shared by the controller modules.
// ----------------------------------------------------------------------------
package lcpc_pkg;

  localparam int unsigned DIP_FRAMES_DEF = 500;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;

  // Configuration register indexes.
  localparam logic [7:0] REG_POS_KP    = 8'd0;
  localparam logic [7:0] REG_POS_KI    = 8'd1;
  localparam logic [7:0] REG_POS_KD    = 8'd2;
  localparam logic [7:0] REG_CUR_KP    = 8'd3;
  localparam logic [7:0] REG_CUR_KI    = 8'd4;
  localparam logic [7:0] REG_SP_BASE   = 8'd5;
  localparam logic [7:0] REG_SP_DIP    = 8'd6;
  localparam logic [7:0] REG_DIP_START = 8'd7;

  // Register reset values.
  localparam logic [23:0] POS_KP_RST    = 24'd1638400;
  localparam logic [23:0] POS_KI_RST    = 24'd8192;
  localparam logic [23:0] POS_KD_RST    = 24'd2457600;
  localparam logic [23:0] CUR_KP_RST    = 24'd196608;
  localparam logic [23:0] CUR_KI_RST    = 24'd491520;
  localparam logic [19:0] SP_BASE_RST   = 20'd83886;
  localparam logic [19:0] SP_DIP_RST    = 20'd75497;
  localparam logic [15:0] DIP_START_RST = 16'd1000;

  // Q7.24 limits.
  localparam logic signed [31:0] IREF_Q       = 32'sd13874758;
  localparam logic signed [31:0] IREF_CLAMP_Q = 32'sd13181020;
  localparam logic signed [31:0] VREF_Q       = 32'sd165423350;
  localparam logic signed [31:0] VREF_CLAMP_Q = 32'sd157152182;

  // Sensor scaling as round-half-up divisions:
  //   y  = (pos * 2^22 + 2557) / 5115
  //   ie = (cur * 838860800 + 11253) / 22506
  // The whole part of each scale over its divisor is split off, so only a
  // short remainder term needs dividing.
  localparam longint unsigned POS_SCALE = 64'd4194304;
  localparam longint unsigned POS_ROUND = 64'd2557;
  localparam longint unsigned POS_DEN   = 64'd5115;
  localparam longint unsigned CUR_SCALE = 64'd838860800;
  localparam longint unsigned CUR_ROUND = 64'd11253;
  localparam longint unsigned CUR_DEN   = 64'd22506;
  localparam logic [7:0]      PWM_FULL  = 8'd254;

  localparam logic [15:0] POS_WHOLE = 16'(POS_SCALE / POS_DEN);
  localparam logic [15:0] POS_FRAC  = 16'(POS_SCALE % POS_DEN);
  localparam logic [15:0] CUR_WHOLE = 16'(CUR_SCALE / CUR_DEN);
  localparam logic [15:0] CUR_FRAC  = 16'(CUR_SCALE % CUR_DEN);

  // Reciprocals scaled by 2^32, rounded down.
  localparam longint unsigned RECIP_ONE = 64'd4294967296;
  localparam logic [19:0] POS_RECIP = 20'(RECIP_ONE / POS_DEN);
  localparam logic [19:0] CUR_RECIP = 20'(RECIP_ONE / CUR_DEN);
  localparam logic [19:0] PWM_RECIP = 20'((RECIP_ONE * 64'(PWM_FULL)) / 64'(VREF_Q));

  typedef enum logic [1:0] {
    DIV_POS, DIV_CUR, DIV_PWM
  } div_sel_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_POS_HI, OP_POS_LO, OP_CUR_HI, OP_CUR_LO,
    OP_DIV_Y, OP_LOAD_Y, OP_DIV_I, OP_LOAD_I, OP_ERR,
    OP_MUL_P, OP_ACC_P, OP_MUL_D, OP_ACC_D, OP_MUL_I, OP_ACC_I, OP_EI,
    OP_MUL_CP, OP_ACC_CP, OP_MUL_CI, OP_ACC_CI, OP_DIV_PWM, OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV_Y, S_WAIT_Y, S_DIV_I, S_WAIT_I, S_ERR,
    S_MUL_P, S_ACC_P, S_MUL_D, S_ACC_D, S_MUL_I, S_ACC_I, S_EI,
    S_MUL_CP, S_ACC_CP, S_MUL_CI, S_ACC_CI, S_DIV_PWM, S_WAIT_PWM, S_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    PH_WAIT, PH_POS_HI, PH_POS_LO, PH_CUR_HI, PH_CUR_LO
  } frame_phase_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr;
    logic div_busy;
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [58:0] v);
    logic signed [31:0] r;
    if (v > 59'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -59'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Integrator with clamp-to-95% anti-windup.
  function automatic logic signed [31:0] integ(input logic signed [31:0] acc,
                                               input logic signed [31:0] inc,
                                               input logic signed [31:0] lim,
                                               input logic signed [31:0] clamp);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = 33'(acc) + 33'(inc);
    if (acc < lim && acc > -lim) begin
      r = sat32(59'(s));
    end else if (acc >= lim) begin
      r = clamp;
    end else begin
      r = -clamp;
    end
    return r;
  endfunction

endpackage

@@ design/lcpc_if.sv @@
// ----------------------------------------------------------------------------
// lcpc interfaces
// Valid/ready channels for received bytes, PWM bytes and register writes.
// ----------------------------------------------------------------------------
interface lcpc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcpc_pwm_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_duty;
  modport source (output valid, output pwm_duty, input ready);
  modport sink (input valid, input pwm_duty, output ready);
endinterface

interface lcpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/lcpc_div.sv @@
// ----------------------------------------------------------------------------
// lcpc_div
// Division by the fixed sensor and PWM scales: reciprocal multiplication
// followed by one correction step.
// ----------------------------------------------------------------------------
module lcpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lcpc_pkg::div_sel_e sel_i,
  input  logic [27:0]        arg_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [47:0]        quot_o
);
  import lcpc_pkg::*;

  div_sel_e    sel_q;
  logic [27:0] arg_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [35:0] num_q, num_c;
  logic [31:0] mul_q, mul_c;
  logic [31:0] base_q, base_c;
  logic [19:0] est_q;
  logic [47:0] quo_q;
  logic [19:0] recip;
  logic [27:0] den;
  logic [51:0] prod;
  logic [47:0] next_mul;
  logic        fits;

  // The quotient is whole * x + (frac * x + round) / den; only the second
  // term is divided, by its 2^32-scaled reciprocal, which undershoots by at
  // most one.
  always_comb begin
    unique case (sel_q)
      DIV_POS: begin
        recip  = POS_RECIP;
        den    = 28'(POS_DEN);
        num_c  = 36'(arg_q[15:0]) * 36'(POS_FRAC) + 36'(POS_ROUND);
        mul_c  = num_c[31:0];
        base_c = 32'(arg_q[15:0]) * 32'(POS_WHOLE);
      end
      DIV_CUR: begin
        recip  = CUR_RECIP;
        den    = 28'(CUR_DEN);
        num_c  = 36'(arg_q[15:0]) * 36'(CUR_FRAC) + 36'(CUR_ROUND);
        mul_c  = num_c[31:0];
        base_c = 32'(arg_q[15:0]) * 32'(CUR_WHOLE);
      end
      default: begin
        recip  = PWM_RECIP;
        den    = VREF_Q[27:0];
        num_c  = 36'(arg_q) * 36'(PWM_FULL);
        mul_c  = 32'(arg_q);
        base_c = '0;
      end
    endcase
  end

  always_comb begin
    prod     = 52'(mul_q) * 52'(recip);
    next_mul = 48'(21'(est_q) + 21'd1) * 48'(den);
    fits     = next_mul <= 48'(num_q);
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      cnt_d  = 2'd3;
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - 2'd1;
      if (cnt_q == 2'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sel_q  <= DIV_POS;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      if (start_i) begin
        sel_q <= sel_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      arg_q <= arg_i;
    end
    if (busy_q && cnt_q == 2'd3) begin
      num_q  <= num_c;
      mul_q  <= mul_c;
      base_q <= base_c;
    end
    if (busy_q && cnt_q == 2'd2) begin
      est_q <= prod[51:32];
    end
    if (busy_q && cnt_q == 2'd1) begin
      quo_q <= 48'(base_q) + 48'(est_q) + 48'(fits);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ design/lcpc_datapath.sv @@
// ----------------------------------------------------------------------------
// lcpc_datapath
// Registers, frame capture, shared multiplier and divider of the PID loops.
// ----------------------------------------------------------------------------
module lcpc_datapath #(
  parameter int unsigned DIP_FRAMES = lcpc_pkg::DIP_FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcpc_pkg::dp_cmd_t  cmd_i,
  output lcpc_pkg::dp_stat_t stat_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic [7:0]         pwm_duty_o
);
  import lcpc_pkg::*;

  logic [23:0] pos_kp_q, pos_ki_q, pos_kd_q, cur_kp_q, cur_ki_q;
  logic [19:0] sp_base_q, sp_dip_q;
  logic [15:0] dip_start_q;

  logic [15:0]        pos_q, cur_q;
  logic signed [31:0] y_q, ie_q, ef_q, prev_q, pint_q, cint_q, ei_q;
  logic signed [33:0] id_q, u_q;
  logic signed [58:0] prod_q;
  logic [31:0]        fcount_q;
  logic [7:0]         pwm_q;

  logic signed [33:0] mul_a;
  logic [23:0]        mul_b;
  logic signed [58:0] prod_d;
  logic signed [31:0] gm, pint_n, cint_n;
  logic signed [33:0] id_sum, id_clamped, u_sum, u_clamped;
  logic [16:0]        dip_end;
  logic               in_dip;
  logic [19:0]        yd;

  logic        div_start;
  div_sel_e    div_sel;
  logic [27:0] div_arg;
  logic [47:0] div_quot;
  logic        div_busy, div_done;

  lcpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sel_i  (div_sel),
    .arg_i  (div_arg),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    div_start = 1'b0;
    div_sel   = DIV_POS;
    div_arg   = '0;
    case (cmd_i.op)
      OP_DIV_Y: begin
        div_start = 1'b1;
        div_sel   = DIV_POS;
        div_arg   = 28'(pos_q);
      end
      OP_DIV_I: begin
        div_start = 1'b1;
        div_sel   = DIV_CUR;
        div_arg   = 28'(cur_q);
      end
      OP_DIV_PWM: begin
        div_start = 1'b1;
        div_sel   = DIV_PWM;
        div_arg   = u_q[27:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_P:  begin mul_a = 34'(ef_q); mul_b = pos_kp_q; end
      OP_MUL_D:  begin mul_a = 34'(ef_q) - 34'(prev_q); mul_b = pos_kd_q; end
      OP_MUL_I:  begin mul_a = 34'(ef_q); mul_b = pos_ki_q; end
      OP_MUL_CP: begin mul_a = 34'(ei_q); mul_b = cur_kp_q; end
      OP_MUL_CI: begin mul_a = 34'(ei_q); mul_b = cur_ki_q; end
      default: ;
    endcase
    prod_d = mul_a * $signed({1'b0, mul_b});
  end

  // Gain product scaled back to Q7.24; the arithmetic shift floors.
  always_comb begin
    gm     = sat32(prod_q >>> 14);
    pint_n = integ(pint_q, gm, IREF_Q, IREF_CLAMP_Q);
    cint_n = integ(cint_q, gm, VREF_Q, VREF_CLAMP_Q);

    id_sum     = id_q + 34'(pint_n);
    id_clamped = id_sum;
    if (id_sum > 34'sd0) id_clamped = '0;
    if (id_sum <= -34'(IREF_Q)) id_clamped = -34'(IREF_Q);

    u_sum     = u_q + 34'(cint_n);
    u_clamped = u_sum;
    if (u_sum > 34'(VREF_Q)) u_clamped = 34'(VREF_Q);
    if (u_sum <= 34'sd0) u_clamped = '0;

    dip_end = 17'(dip_start_q) + 17'(DIP_FRAMES);
    in_dip  = (fcount_q > 32'(dip_start_q)) && (fcount_q <= 32'(dip_end));
    yd      = in_dip ? sp_dip_q : sp_base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_kp_q    <= POS_KP_RST;
      pos_ki_q    <= POS_KI_RST;
      pos_kd_q    <= POS_KD_RST;
      cur_kp_q    <= CUR_KP_RST;
      cur_ki_q    <= CUR_KI_RST;
      sp_base_q   <= SP_BASE_RST;
      sp_dip_q    <= SP_DIP_RST;
      dip_start_q <= DIP_START_RST;
      pint_q      <= '0;
      cint_q      <= '0;
      prev_q      <= '0;
      fcount_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_POS_KP:    pos_kp_q    <= cfg_data_i[23:0];
          REG_POS_KI:    pos_ki_q    <= cfg_data_i[23:0];
          REG_POS_KD:    pos_kd_q    <= cfg_data_i[23:0];
          REG_CUR_KP:    cur_kp_q    <= cfg_data_i[23:0];
          REG_CUR_KI:    cur_ki_q    <= cfg_data_i[23:0];
          REG_SP_BASE:   sp_base_q   <= cfg_data_i[19:0];
          REG_SP_DIP:    sp_dip_q    <= cfg_data_i[19:0];
          REG_DIP_START: dip_start_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACC_I) begin
        pint_q <= pint_n;
      end
      if (cmd_i.op == OP_ACC_CI) begin
        cint_q <= cint_n;
        prev_q <= ef_q;
        if (fcount_q != '1) fcount_q <= fcount_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      OP_POS_HI: pos_q <= {rx_byte_i, 8'h00};
      OP_POS_LO: pos_q <= {pos_q[15:8], rx_byte_i};
      OP_CUR_HI: cur_q <= {rx_byte_i, 8'h00};
      OP_CUR_LO: cur_q <= {cur_q[15:8], rx_byte_i};
      OP_LOAD_Y: y_q   <= $signed({1'b0, div_quot[30:0]});
      OP_LOAD_I: ie_q  <= (|div_quot[47:31]) ? 32'sh7FFFFFFF
                                             : $signed({1'b0, div_quot[30:0]});
      OP_ERR:    ef_q  <= $signed({12'b0, yd}) - y_q;
      OP_ACC_P:  id_q  <= 34'(gm);
      OP_ACC_D:  id_q  <= id_q + 34'(gm);
      OP_ACC_I:  id_q  <= id_clamped;
      OP_EI:     ei_q  <= 32'(-id_q - 34'(ie_q));
      OP_ACC_CP: u_q   <= 34'(gm);
      OP_ACC_CI: u_q   <= u_clamped;
      OP_OUT:    pwm_q <= div_quot[7:0];
      default: ;
    endcase
  end

  assign stat_o.hdr      = (rx_byte_i == HEADER_BYTE);
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;
  assign pwm_duty_o      = pwm_q;

endmodule

@@ design/lcpc_ctrl.sv @@
`include "levitation_cascade_pid_controller_assert.svh"
// ----------------------------------------------------------------------------
// lcpc_ctrl
// Frame parser and sequencer of the control computation.
// ----------------------------------------------------------------------------
module lcpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  lcpc_pkg::dp_stat_t stat_i,
  output lcpc_pkg::dp_cmd_t  cmd_o
);
  import lcpc_pkg::*;

  ctrl_state_e  state_q, state_d;
  frame_phase_e phase_q, phase_d;
  logic         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (phase_q)
            PH_WAIT:   if (stat_i.hdr) phase_d = PH_POS_HI;
            PH_POS_HI: begin cmd_o.op = OP_POS_HI; phase_d = PH_POS_LO; end
            PH_POS_LO: begin cmd_o.op = OP_POS_LO; phase_d = PH_CUR_HI; end
            PH_CUR_HI: begin cmd_o.op = OP_CUR_HI; phase_d = PH_CUR_LO; end
            PH_CUR_LO: begin
              cmd_o.op = OP_CUR_LO;
              phase_d  = PH_WAIT;
              state_d  = S_DIV_Y;
            end
            default: phase_d = PH_WAIT;
          endcase
        end
      end
      S_DIV_Y:  begin cmd_o.op = OP_DIV_Y; state_d = S_WAIT_Y; end
      S_WAIT_Y: if (stat_i.div_done) begin cmd_o.op = OP_LOAD_Y; state_d = S_DIV_I; end
      S_DIV_I:  begin cmd_o.op = OP_DIV_I; state_d = S_WAIT_I; end
      S_WAIT_I: if (stat_i.div_done) begin cmd_o.op = OP_LOAD_I; state_d = S_ERR; end
      S_ERR:    begin cmd_o.op = OP_ERR;    state_d = S_MUL_P;  end
      S_MUL_P:  begin cmd_o.op = OP_MUL_P;  state_d = S_ACC_P;  end
      S_ACC_P:  begin cmd_o.op = OP_ACC_P;  state_d = S_MUL_D;  end
      S_MUL_D:  begin cmd_o.op = OP_MUL_D;  state_d = S_ACC_D;  end
      S_ACC_D:  begin cmd_o.op = OP_ACC_D;  state_d = S_MUL_I;  end
      S_MUL_I:  begin cmd_o.op = OP_MUL_I;  state_d = S_ACC_I;  end
      S_ACC_I:  begin cmd_o.op = OP_ACC_I;  state_d = S_EI;     end
      S_EI:     begin cmd_o.op = OP_EI;     state_d = S_MUL_CP; end
      S_MUL_CP: begin cmd_o.op = OP_MUL_CP; state_d = S_ACC_CP; end
      S_ACC_CP: begin cmd_o.op = OP_ACC_CP; state_d = S_MUL_CI; end
      S_MUL_CI: begin cmd_o.op = OP_MUL_CI; state_d = S_ACC_CI; end
      S_ACC_CI: begin cmd_o.op = OP_ACC_CI; state_d = S_DIV_PWM; end
      S_DIV_PWM: begin cmd_o.op = OP_DIV_PWM; state_d = S_WAIT_PWM; end
      S_WAIT_PWM: if (stat_i.div_done) state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `LCPC_ASSERT_NXT(a_div_starts, cmd_o.op == OP_DIV_Y || cmd_o.op == OP_DIV_PWM, stat_i.div_busy, "divider did not start")
  `LCPC_ASSERT_IMP(a_phase_rest, state_q != S_IDLE, phase_q == PH_WAIT, "frame phase moved during compute")
  `LCPC_ASSERT_NXT(a_out_loaded, cmd_o.op == OP_OUT, out_valid_q, "result beat not presented")

endmodule

@@ design/levitation_cascade_pid_controller.sv @@
// ----------------------------------------------------------------------------
// levitation_cascade_pid_controller
// Cascaded position PID and current PI loop driven by a serial sensor stream.
// ----------------------------------------------------------------------------
// Usage: rx_i carries one received serial byte per beat. A frame is the header
// byte 0xAA followed by big-endian 16-bit position and current readings; other
// bytes seen while waiting for a header are dropped. Each complete frame yields
// one beat on pwm_o carrying the PWM duty byte (0..254).
// cfg_i writes the eight gain and setpoint registers by index; unknown indexes
// are ignored. It is always ready and should be used only while the block idles.
// Input: header and data bytes are taken as they are offered while the block
// idles. The fifth byte of a frame starts the computation, which holds rx_i
// not ready through three scaling divisions (position, current, PWM), each
// waiting for the reciprocal divider, the error step, ten multiply and
// accumulate steps on the one shared multiplier, the current error step, and
// the load of the output register, with which the PWM beat becomes valid.
// The PWM beat sits in an output register, so bytes of the next frame are still
// taken while it waits. If a new result is ready before the old one is taken,
// the block holds it and stays not ready until the receiver frees the register.
// Reset returns the configuration registers to their defaults, clears the
// integrators, the previous error and the frame count, and waits for a header.
// ----------------------------------------------------------------------------
module levitation_cascade_pid_controller #(
  parameter int unsigned DIP_FRAMES = lcpc_pkg::DIP_FRAMES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcpc_rx_if.sink    rx_i,
  lcpc_pwm_if.source pwm_o,
  lcpc_cfg_if.sink   cfg_i
);
  import lcpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  // Sequencer: parses frame bytes and walks the loop computation.
  lcpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(pwm_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: registers, loop state, multiplier and divider.
  lcpc_datapath #(
    .DIP_FRAMES(DIP_FRAMES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .rx_byte_i  (rx_i.rx_byte),
    .cfg_we_i   (cfg_i.valid),
    .cfg_index_i(cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .pwm_duty_o (pwm_o.pwm_duty)
  );

  assign rx_i.ready  = in_ready;
  assign pwm_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cascaded levitation PID controller.
// It streams sensor frames, noise and broken frames into the block under
// several register settings. A built-in predictor computes each expected PWM
// byte, and every PWM beat is checked in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcpc_pkg::*;

  localparam logic [7:0] REG_UNUSED = 8'd8;   // No register has this index.
  localparam logic [7:0] REG_FAR    = 8'd255;
  localparam int unsigned SETTLE_CYCLES = 400;  // Longer than one computation.
  localparam longint MAX_FRAMES = 64'hFFFF_FFFF;

  logic clk_i;
  logic rst_ni;

  lcpc_rx_if  rx ();
  lcpc_pwm_if pwm ();
  lcpc_cfg_if cfg ();

  levitation_cascade_pid_controller dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx.sink),
    .pwm_o (pwm.source),
    .cfg_i (cfg.sink)
  );

  // The clock runs with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the register file, updated when a write beat is taken.
  logic [23:0] pos_kp, pos_ki, pos_kd, cur_kp, cur_ki;
  logic [19:0] sp_base, sp_dip;
  logic [15:0] dip_start;

  // Shadow copy of the controller state.
  frame_phase_e next_field;   // Which byte of the frame comes next.
  logic [15:0]  pos_raw, cur_raw;
  longint       pos_integ, cur_integ, last_pos_err, frames_done;

  // Bytes still to be sent and PWM bytes still to be seen.
  logic [7:0] rx_pending[$];
  logic [7:0] duty_expected[$];

  int  mismatches;
  int  duty_beats;
  int  noise_sent;
  bit  calm;        // While set, neither side idles.
  bit  rx_took;     // The rx beat in flight was taken at the last rising edge.

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q7.24 value times Q10.14 gain, floored back to Q7.24 and saturated.
  function automatic longint apply_gain(longint x, logic [23:0] g);
    longint p;
    longint q;
    p = x * longint'({40'd0, g});
    if (p >= 0) q = p / 16384;
    else q = -((-p + 16383) / 16384);
    return clip32(q);
  endfunction

  // Integrator step with clamp-to-95% anti-windup.
  function automatic longint windup_step(longint acc, longint inc, longint lim,
                                         longint clamp);
    if (acc < lim && acc > -lim) return clip32(acc + inc);
    if (acc >= lim) return clamp;
    return -clamp;
  endfunction

  // One pass of both loops on the stored readings; returns the PWM byte.
  function automatic logic [7:0] run_loops();
    longint y, ie, yd, ef, id, ei, u;
    y  = (longint'(pos_raw) * 64'd83886080 + 64'd51150) / 64'd102300;
    ie = clip32((longint'(cur_raw) * 64'd838860800 + 64'd11253) / 64'd22506);
    if (frames_done > longint'(dip_start) &&
        frames_done <= longint'(dip_start) + DIP_FRAMES_DEF) begin
      yd = longint'(sp_dip);
    end else begin
      yd = longint'(sp_base);
    end
    ef = clip32(yd - y);
    id = apply_gain(ef, pos_kp) + apply_gain(ef - last_pos_err, pos_kd);
    pos_integ = windup_step(pos_integ, apply_gain(ef, pos_ki), IREF_Q, IREF_CLAMP_Q);
    id += pos_integ;
    if (id > 0) id = 0;
    if (id <= -longint'(IREF_Q)) id = -longint'(IREF_Q);
    ei = -id - ie;
    u = apply_gain(ei, cur_kp);
    cur_integ = windup_step(cur_integ, apply_gain(ei, cur_ki), VREF_Q, VREF_CLAMP_Q);
    u += cur_integ;
    if (u > longint'(VREF_Q)) u = VREF_Q;
    if (u <= 0) u = 0;
    last_pos_err = ef;
    if (frames_done != MAX_FRAMES) frames_done++;
    return 8'((u * 254) / longint'(VREF_Q));
  endfunction

  // Frame parser: advances on every taken byte and queues a PWM byte at the
  // end of each complete frame.
  task automatic absorb_byte(logic [7:0] b);
    case (next_field)
      PH_WAIT: begin
        // Anything but a header is dropped while waiting.
        if (b == HEADER_BYTE) begin
          pos_raw = '0;
          cur_raw = '0;
          next_field = PH_POS_HI;
        end
      end
      PH_POS_HI: begin
        pos_raw = {b, 8'h00};
        next_field = PH_POS_LO;
      end
      PH_POS_LO: begin
        pos_raw[7:0] = b;
        next_field = PH_CUR_HI;
      end
      PH_CUR_HI: begin
        cur_raw = {b, 8'h00};
        next_field = PH_CUR_LO;
      end
      default: begin
        cur_raw[7:0] = b;
        next_field = PH_WAIT;
        duty_expected.push_back(run_loops());
      end
    endcase
  endtask

  function automatic bit want_idle();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // Monitor: predicts on every taken rx beat and checks every PWM beat.
  always @(posedge clk_i) begin
    logic [7:0] want;
    rx_took = rst_ni && rx.valid && rx.ready;
    if (rx_took) absorb_byte(rx.rx_byte);
    if (rst_ni && pwm.valid && pwm.ready) begin
      duty_beats++;
      if (duty_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected PWM beat, expected none, actual duty %0d",
                 $time, pwm.pwm_duty);
      end else begin
        want = duty_expected.pop_front();
        if (pwm.pwm_duty !== want) begin
          mismatches++;
          $display("%0t: pwm_duty mismatch, expected %0d, actual %0d",
                   $time, want, pwm.pwm_duty);
        end
      end
    end
  end

  // Driver: offers the next pending byte once the previous beat was taken,
  // with random gaps. The PWM ready is stalled at random too.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!rx.valid || rx_took) begin
        if (rx_pending.size() != 0 && !want_idle()) begin
          rx.valid   <= 1'b1;
          rx.rx_byte <= rx_pending.pop_front();
        end else begin
          rx.valid <= 1'b0;
        end
      end
      pwm.ready <= !want_idle();
    end
  end

  task automatic load_frame(logic [15:0] pos, logic [15:0] cur);
    rx_pending.push_back(HEADER_BYTE);
    rx_pending.push_back(pos[15:8]);
    rx_pending.push_back(pos[7:0]);
    rx_pending.push_back(cur[15:8]);
    rx_pending.push_back(cur[7:0]);
  endtask

  // Waits until every byte went in and every PWM beat came out, then lets the
  // block finish any computation that produces nothing further.
  task automatic settle();
    do @(posedge clk_i);
    while (rx_pending.size() != 0 || rx.valid || duty_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i);
    while (!cfg.ready);
    case (idx)
      REG_POS_KP:    pos_kp    = val[23:0];
      REG_POS_KI:    pos_ki    = val[23:0];
      REG_POS_KD:    pos_kd    = val[23:0];
      REG_CUR_KP:    cur_kp    = val[23:0];
      REG_CUR_KI:    cur_ki    = val[23:0];
      REG_SP_BASE:   sp_base   = val[19:0];
      REG_SP_DIP:    sp_dip    = val[19:0];
      REG_DIP_START: dip_start = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] ckp, logic [31:0] cki, logic [31:0] base,
                           logic [31:0] dip, logic [31:0] start);
    write_reg(REG_POS_KP, kp);
    write_reg(REG_POS_KI, ki);
    write_reg(REG_POS_KD, kd);
    write_reg(REG_CUR_KP, ckp);
    write_reg(REG_CUR_KI, cki);
    write_reg(REG_SP_BASE, base);
    write_reg(REG_SP_DIP, dip);
    write_reg(REG_DIP_START, start);
  endtask

  // Random traffic: mostly whole frames, some near the operating point so the
  // loops stay out of their clamps, plus noise and loose bytes that break up
  // the framing.
  task automatic load_random(int budget);
    int sent;
    int pick;
    logic [7:0] b;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        do b = 8'($urandom);
        while (b == HEADER_BYTE);
        rx_pending.push_back(b);
        noise_sent++;
      end else if (pick < 15) begin
        rx_pending.push_back(8'($urandom));
        sent++;
      end else if (pick < 60) begin
        load_frame(16'($urandom_range(400)), 16'($urandom_range(3000)));
        sent += 5;
      end else begin
        load_frame(16'($urandom), 16'($urandom));
        sent += 5;
      end
    end
  endtask

  initial begin
    mismatches  = 0;
    duty_beats  = 0;
    noise_sent  = 0;
    calm        = 1'b0;
    rx_took     = 1'b0;
    rst_ni      = 1'b0;
    rx.valid    = 1'b0;
    rx.rx_byte  = '0;
    pwm.ready   = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    pos_kp = POS_KP_RST;  pos_ki = POS_KI_RST;  pos_kd = POS_KD_RST;
    cur_kp = CUR_KP_RST;  cur_ki = CUR_KI_RST;
    sp_base = SP_BASE_RST;  sp_dip = SP_DIP_RST;  dip_start = DIP_START_RST;
    next_field = PH_WAIT;
    pos_raw = '0;  cur_raw = '0;
    pos_integ = 0;  cur_integ = 0;  last_pos_err = 0;  frames_done = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings: bytes before any header, zero and
    // full-scale readings, a current large enough to saturate, and header
    // bytes that arrive as frame data.
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(8'h55);
    load_frame(16'h0000, 16'h0000);
    load_frame(16'hFFFF, 16'hFFFF);
    load_frame(16'd102, 16'h0000);
    load_frame(16'h0000, 16'hFFFF);
    load_frame({HEADER_BYTE, HEADER_BYTE}, {HEADER_BYTE, HEADER_BYTE});
    settle();

    // Default settings.
    load_random(300);
    settle();

    // Step setpoint from the first frame on; writes to unknown indexes are
    // dropped by the block.
    write_all(POS_KP_RST, POS_KI_RST, POS_KD_RST, CUR_KP_RST, CUR_KI_RST,
              SP_BASE_RST, SP_DIP_RST, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_FAR, 32'd0);
    load_random(300);
    settle();

    // Lowest extreme: all gains and setpoints zero.
    write_all(0, 0, 0, 0, 0, 0, 0, 0);
    load_random(300);
    settle();

    // Highest extreme: full-scale gains, setpoints at their top.
    write_all(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
              32'd838861, 32'd838861, 32'hFFFF);
    load_random(300);
    settle();

    // Random words, whose bits above each register's width the registers drop.
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
    load_random(300);
    settle();

    // Defaults again with the step window open now, and no idling at all.
    write_all(POS_KP_RST, POS_KI_RST, POS_KD_RST, CUR_KP_RST, CUR_KI_RST,
              SP_BASE_RST, SP_DIP_RST, 32'(frames_done));
    calm = 1'b1;
    load_random(300);
    settle();

    $display("Run covered %0d frames and %0d PWM beats over six register settings,",
             frames_done, duty_beats);
    $display("with %0d noise bytes mixed in.", noise_sent);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
